// ===== hw/rtl/lstb_pkg.sv =====
// Shared types and constants of the link shaper (token bucket, delay, loss).
// Used by lstb_front, lstb_back and link_shaper_token_bucket_delay.
package lstb_pkg;

  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [9:0]  USEC_PER_MS  = 10'd1000;

  typedef enum logic {
    OP_ARRIVAL = 1'b0,
    OP_TICK    = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    VERDICT_QUEUED  = 3'd0,
    VERDICT_LOST    = 3'd1,
    VERDICT_LIMIT   = 3'd2,
    VERDICT_FULL    = 3'd3,
    VERDICT_RELEASE = 3'd4
  } verdict_t;

  typedef enum logic [2:0] {
    CFG_RATE  = 3'd0,
    CFG_BURST = 3'd1,
    CFG_DELAY = 3'd2,
    CFG_LOSS  = 3'd3,
    CFG_LIMIT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    op_t         op;
    logic [47:0] now_us;
    logic [15:0] length;
    logic [15:0] tag;
    logic        lost;
  } cmd_t;

  typedef struct packed {
    logic [47:0] arrival;
    logic [15:0] length;
    logic [15:0] tag;
  } slot_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL0,
    BK_MUL1,
    BK_ADD,
    BK_FILL,
    BK_CAP,
    BK_READ,
    BK_EVAL,
    BK_DEC,
    BK_DONE
  } back_state_t;

endpackage

// ===== hw/rtl/lstb_front.sv =====
// Front part: accepts items, makes the loss decision, queues commands.
// Depends on lstb_pkg for cmd_t and op_t.
module lstb_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_operation,
  input  logic [47:0]      in_now_us,
  input  logic [15:0]      in_packet_length,
  input  logic [15:0]      in_packet_tag,
  input  logic [13:0]      in_loss_draw,
  input  logic [13:0]      loss_cfg,
  output logic             cmd_valid,
  output lstb_pkg::cmd_t   cmd,
  input  logic             cmd_pop
);

  lstb_pkg::cmd_t fifo_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  lstb_pkg::cmd_t cmd_in;

  // classify the arriving item
  always_comb begin
    cmd_in.op     = lstb_pkg::op_t'(in_operation);
    cmd_in.now_us = in_now_us;
    cmd_in.length = in_packet_length;
    cmd_in.tag    = in_packet_tag;
    cmd_in.lost   = (loss_cfg != 14'd0) && (in_loss_draw <= loss_cfg);
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = fifo_r[rd_ptr_r];

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== hw/rtl/lstb_back.sv =====
// Back part: packet FIFO, token bucket refill and release sequencer.
// Depends on lstb_pkg for cmd_t, slot_t, verdict_t and back_state_t.
module lstb_back #(
  parameter int QUEUE_SLOTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  lstb_pkg::cmd_t   cmd,
  output logic             cmd_pop,
  input  logic [31:0]      rate_cfg,
  input  logic [23:0]      burst_cfg,
  input  logic [15:0]      delay_cfg,
  input  logic [23:0]      limit_cfg,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_verdict,
  output logic [15:0]      out_tag,
  output logic [15:0]      out_length,
  output logic             out_last
);

  localparam int QW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int CW = $clog2(QUEUE_SLOTS + 1);
  localparam logic [QW-1:0] LAST_IDX = QW'(QUEUE_SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_SLOTS);

  lstb_pkg::back_state_t state_r, state_nxt;

  lstb_pkg::slot_t mem [QUEUE_SLOTS];
  lstb_pkg::slot_t rd_q;
  logic            wr_en;

  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [23:0]   stored_r, stored_nxt;
  logic [63:0]   tokens_r, tokens_nxt;
  logic [47:0]   last_tick_r, last_tick_nxt;
  logic [47:0]   now_r, now_nxt;
  logic [47:0]   delta_r, delta_nxt;
  logic [63:0]   p0_r, p0_nxt;
  logic [47:0]   p1_r, p1_nxt;
  logic [63:0]   add_r, add_nxt;
  logic [43:0]   cap_r, cap_nxt;
  logic [25:0]   dly_r, dly_nxt;
  logic [35:0]   need_r, need_nxt;
  logic          age_ok_r, age_ok_nxt;

  logic          pend_r, pend_nxt;
  logic [15:0]   pend_tag_r, pend_tag_nxt;
  logic [15:0]   pend_len_r, pend_len_nxt;

  logic          out_valid_r;
  logic [2:0]    out_verdict_r;
  logic [15:0]   out_tag_r, out_length_r;
  logic          out_last_r;

  logic          load_ok;
  logic          emit_en;
  logic [2:0]    emit_verdict;
  logic [15:0]   emit_tag, emit_len;
  logic          emit_last;

  logic [24:0]   stored_sum;
  logic [79:0]   prod;
  logic [64:0]   tsum;
  logic [47:0]   age;

  assign load_ok    = !out_valid_r || out_ready;
  assign stored_sum = {1'b0, stored_r} + {9'd0, cmd.length};
  assign prod       = {16'd0, p0_r} + {p1_r, 32'd0};
  assign tsum       = {1'b0, tokens_r} + {1'b0, add_r};
  assign age        = now_r - rd_q.arrival;

  // sequence arrivals, refill and releases
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    stored_nxt    = stored_r;
    tokens_nxt    = tokens_r;
    last_tick_nxt = last_tick_r;
    now_nxt       = now_r;
    delta_nxt     = delta_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    add_nxt       = add_r;
    cap_nxt       = cap_r;
    dly_nxt       = dly_r;
    need_nxt      = need_r;
    age_ok_nxt    = age_ok_r;
    pend_nxt      = pend_r;
    pend_tag_nxt  = pend_tag_r;
    pend_len_nxt  = pend_len_r;
    cmd_pop       = 1'b0;
    wr_en         = 1'b0;
    emit_en       = 1'b0;
    emit_verdict  = lstb_pkg::VERDICT_QUEUED;
    emit_tag      = cmd.tag;
    emit_len      = cmd.length;
    emit_last     = 1'b1;
    unique case (state_r)
      lstb_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == lstb_pkg::OP_ARRIVAL) begin
            if (load_ok) begin
              cmd_pop = 1'b1;
              emit_en = 1'b1;
              priority if (cmd.lost) begin
                emit_verdict = lstb_pkg::VERDICT_LOST;
              end else if (stored_sum >= {1'b0, limit_cfg}) begin
                emit_verdict = lstb_pkg::VERDICT_LIMIT;
              end else if (count_r == FULL_CNT) begin
                emit_verdict = lstb_pkg::VERDICT_FULL;
              end else begin
                wr_en      = 1'b1;
                tail_nxt   = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
                count_nxt  = count_r + 1'b1;
                stored_nxt = stored_sum[23:0];
              end
            end
          end else begin
            cmd_pop       = 1'b1;
            now_nxt       = cmd.now_us;
            delta_nxt     = (cmd.now_us >= last_tick_r) ? cmd.now_us - last_tick_r : '0;
            last_tick_nxt = cmd.now_us;
            state_nxt     = lstb_pkg::BK_MUL0;
          end
        end
      end
      lstb_pkg::BK_MUL0: begin
        p0_nxt    = 64'(rate_cfg) * 64'(delta_r[31:0]);
        cap_nxt   = 44'(burst_cfg) * 44'(lstb_pkg::USEC_PER_SEC);
        state_nxt = lstb_pkg::BK_MUL1;
      end
      lstb_pkg::BK_MUL1: begin
        p1_nxt    = 48'(rate_cfg) * 48'(delta_r[47:32]);
        dly_nxt   = 26'(delay_cfg) * 26'(lstb_pkg::USEC_PER_MS);
        state_nxt = lstb_pkg::BK_ADD;
      end
      lstb_pkg::BK_ADD: begin
        // saturate the refill product at 64 bits
        add_nxt   = (prod[79:64] != 16'd0) ? '1 : prod[63:0];
        state_nxt = lstb_pkg::BK_FILL;
      end
      lstb_pkg::BK_FILL: begin
        tokens_nxt = tsum[64] ? '1 : tsum[63:0];
        state_nxt  = lstb_pkg::BK_CAP;
      end
      lstb_pkg::BK_CAP: begin
        if (tokens_r > {20'd0, cap_r}) begin
          tokens_nxt = {20'd0, cap_r};
        end
        state_nxt = lstb_pkg::BK_READ;
      end
      lstb_pkg::BK_READ: begin
        // head entry is read this cycle
        state_nxt = (count_r == '0) ? lstb_pkg::BK_DONE : lstb_pkg::BK_EVAL;
      end
      lstb_pkg::BK_EVAL: begin
        need_nxt   = 36'(rd_q.length) * 36'(lstb_pkg::USEC_PER_SEC);
        age_ok_nxt = (now_r >= rd_q.arrival) && (age >= {22'd0, dly_r});
        state_nxt  = lstb_pkg::BK_DEC;
      end
      lstb_pkg::BK_DEC: begin
        if (age_ok_r && (tokens_r > {28'd0, need_r})) begin
          // push the previous release before taking this one
          if (!pend_r || load_ok) begin
            if (pend_r) begin
              emit_en      = 1'b1;
              emit_verdict = lstb_pkg::VERDICT_RELEASE;
              emit_tag     = pend_tag_r;
              emit_len     = pend_len_r;
              emit_last    = 1'b0;
            end
            pend_nxt     = 1'b1;
            pend_tag_nxt = rd_q.tag;
            pend_len_nxt = rd_q.length;
            tokens_nxt   = tokens_r - {28'd0, need_r};
            stored_nxt   = (stored_r >= {8'd0, rd_q.length}) ?
                           stored_r - {8'd0, rd_q.length} : '0;
            head_nxt     = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
            count_nxt    = count_r - 1'b1;
            state_nxt    = lstb_pkg::BK_READ;
          end
        end else begin
          state_nxt = lstb_pkg::BK_DONE;
        end
      end
      lstb_pkg::BK_DONE: begin
        if (!pend_r) begin
          state_nxt = lstb_pkg::BK_IDLE;
        end else if (load_ok) begin
          emit_en      = 1'b1;
          emit_verdict = lstb_pkg::VERDICT_RELEASE;
          emit_tag     = pend_tag_r;
          emit_len     = pend_len_r;
          emit_last    = 1'b1;
          pend_nxt     = 1'b0;
          state_nxt    = lstb_pkg::BK_IDLE;
        end
      end
      default: state_nxt = lstb_pkg::BK_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lstb_pkg::BK_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      stored_r    <= '0;
      tokens_r    <= '0;
      last_tick_r <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      stored_r    <= stored_nxt;
      tokens_r    <= tokens_nxt;
      last_tick_r <= last_tick_nxt;
      pend_r      <= pend_nxt;
      if (emit_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    delta_r    <= delta_nxt;
    p0_r       <= p0_nxt;
    p1_r       <= p1_nxt;
    add_r      <= add_nxt;
    cap_r      <= cap_nxt;
    dly_r      <= dly_nxt;
    need_r     <= need_nxt;
    age_ok_r   <= age_ok_nxt;
    pend_tag_r <= pend_tag_nxt;
    pend_len_r <= pend_len_nxt;
    if (emit_en) begin
      out_verdict_r <= emit_verdict;
      out_tag_r     <= emit_tag;
      out_length_r  <= emit_len;
      out_last_r    <= emit_last;
    end
  end

  // packet slot memory: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= '{arrival: cmd.now_us, length: cmd.length, tag: cmd.tag};
    end
    rd_q <= mem[head_r];
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;
  assign out_tag     = out_tag_r;
  assign out_length  = out_length_r;
  assign out_last    = out_last_r;

endmodule

// ===== hw/rtl/link_shaper_token_bucket_delay.sv =====
// Top level of the link shaper: configuration registers, front and back.
// Depends on lstb_pkg, lstb_front and lstb_back.
//
// Usage: items enter on in_* (valid/ready). operation 0 is a packet
// arrival and gives exactly one result item: queued, lost, dropped on the
// byte limit or dropped on full slots. operation 1 is a timer tick: it
// refills the token bucket and releases head packets that are old enough
// and covered by tokens, one result each, the final one with out_last set;
// a tick that releases nothing gives no result.
// Sequence: an arrival is first written into the two-entry command queue;
// the back part, when idle and with a free output register, reads the
// queue directly and loads the result register. A tick, once it leaves the
// queue, refills in steps: elapsed time, two partial products, product
// saturation, add, cap; each released packet then passes read, evaluate
// and decide over the slot memory, and a closing done step emits the last
// release when the output is free. Configuration (cfg_*) is always ready;
// the user must write it only while idle; the block does not enforce this.
// Reset empties the queue, clears tokens and time, and loads register
// defaults (burst and queue limit 65536). A stalled out_ready holds the
// result register; the command queue keeps accepting until it is full.
module link_shaper_token_bucket_delay #(
  parameter int QUEUE_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [47:0] in_now_us,
  input  logic [15:0] in_packet_length,
  input  logic [15:0] in_packet_tag,
  input  logic [13:0] in_loss_draw,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict,
  output logic [15:0] out_tag,
  output logic [15:0] out_length,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] rate_r;
  logic [23:0] burst_r;
  logic [15:0] delay_r;
  logic [13:0] loss_r;
  logic [23:0] limit_r;

  logic           cmd_valid;
  logic           cmd_pop;
  lstb_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= 32'd0;
      burst_r <= 24'd65536;
      delay_r <= 16'd0;
      loss_r  <= 14'd0;
      limit_r <= 24'd65536;
    end else if (cfg_valid) begin
      unique case (lstb_pkg::cfg_idx_t'(cfg_index))
        lstb_pkg::CFG_RATE:  rate_r  <= cfg_data;
        lstb_pkg::CFG_BURST: burst_r <= cfg_data[23:0];
        lstb_pkg::CFG_DELAY: delay_r <= cfg_data[15:0];
        lstb_pkg::CFG_LOSS:  loss_r  <= cfg_data[13:0];
        lstb_pkg::CFG_LIMIT: limit_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  lstb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_now_us        (in_now_us),
    .in_packet_length (in_packet_length),
    .in_packet_tag    (in_packet_tag),
    .in_loss_draw     (in_loss_draw),
    .loss_cfg         (loss_r),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop)
  );

  lstb_back #(
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .rate_cfg    (rate_r),
    .burst_cfg   (burst_r),
    .delay_cfg   (delay_r),
    .limit_cfg   (limit_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_verdict (out_verdict),
    .out_tag     (out_tag),
    .out_length  (out_length),
    .out_last    (out_last)
  );

endmodule
